[sv/vtp_pkg.sv]
// Shared widths, types, helper functions and sine/cosine tables of the vertex transform.
package vtp_pkg;

    localparam int VW     = 13;     // vertex coordinate
    localparam int TW     = 11;     // translation register
    localparam int PCTW   = 10;     // scale percent register
    localparam int DEGW   = 9;      // one rotation angle
    localparam int ROTW   = 3 * DEGW;
    localparam int ADDRW  = 3;
    localparam int CFGW   = ROTW;
    localparam int SW16   = 16;     // centering arithmetic
    localparam int AW     = 15;     // centered coordinate
    localparam int PW     = AW + PCTW + 1;
    localparam int MW     = PW - 1;
    localparam int RCPW   = 26;
    localparam int RSH    = 32;
    localparam int BW     = 19;     // scaled coordinate
    localparam int RW     = 24;     // rotated coordinate
    localparam int CW     = 32;     // Q30 sine or cosine, signed
    localparam int PRW    = RW + CW;
    localparam int SW     = PRW + 2;
    localparam int XW     = 25;     // translated coordinate and depth
    localparam int NW     = 40;     // projection numerator
    localparam int DW     = 26;     // projection denominator
    localparam int QW     = 17;     // quotient bits before saturation
    localparam int OW     = 16;
    localparam int TAB_N  = 90;
    localparam int TABIW  = 7;
    localparam int QTW    = 31;

    // Reciprocal of 100 scaled by 2^32, rounded up; exact for magnitudes below 2^30.
    localparam logic [RCPW-1:0] RCP100 = RCPW'(42949673);
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q32  = 64'd13493037705;

    typedef enum logic [ADDRW-1:0] {
        REG_TRANS_X = 3'd0,
        REG_TRANS_Y = 3'd1,
        REG_TRANS_Z = 3'd2,
        REG_SCALE_X = 3'd3,
        REG_SCALE_Y = 3'd4,
        REG_SCALE_Z = 3'd5,
        REG_ROT     = 3'd6
    } reg_idx_t;

    typedef logic [QTW-1:0] q30_tab_t [TAB_N];

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic dz;
    } side_t;

    typedef struct packed {
        logic                 saturated;
        logic                 depth_zero;
        logic signed [OW-1:0] screen_y;
        logic signed [OW-1:0] screen_x;
    } res_t;

    // Halve with truncation toward zero.
    function automatic logic signed [SW16-1:0] half_trunc(input logic signed [SW16-1:0] p);
        logic signed [SW16-1:0] s;
        s = p + $signed({{(SW16-1){1'b0}}, p[SW16-1]});
        return s >>> 1;
    endfunction

    // Divide by 2^30 with truncation toward zero.
    function automatic logic signed [SW-1:0] trunc_q30(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] adj;
        adj = s[SW-1] ? $signed(SW'(Q30_ONE - 64'd1)) : '0;
        return (s + adj) >>> 30;
    endfunction

    // Unsigned long division by shift and subtract, used only to build the tables.
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30 for whole degrees 0..89.
    function automatic q30_tab_t build_tab(input bit want_sin);
        q30_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   dv;
        longint            sum;
        for (int r = 0; r < TAB_N; r++)
        begin
            x    = udiv(64'(r) * PI_Q32 + 64'd360, 64'd720);
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = want_sin ? x : Q30_ONE;
            sum  = longint'(term);
            for (int k = 1; k <= 9; k++)
            begin
                dv = want_sin ? 64'(2 * k) * 64'(2 * k + 1) : 64'(2 * k - 1) * 64'(2 * k);
                term = udiv((term * x2) >> 30, dv);
                if ((k & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > longint'(Q30_ONE))
                sum = longint'(Q30_ONE);
            tab[r] = QTW'(sum);
        end
        return tab;
    endfunction

    localparam q30_tab_t SIN_TAB = build_tab(1'b1);
    localparam q30_tab_t COS_TAB = build_tab(1'b0);

endpackage

[sv/vtp_trig.sv]
// Sine and cosine of one whole-degree angle, two register stages.
module vtp_trig import vtp_pkg::*;
(
    input  logic                 clk,
    input  logic [DEGW-1:0]      deg,
    output logic signed [CW-1:0] sin_q,
    output logic signed [CW-1:0] cos_q
);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    logic [DEGW-1:0]      ang;
    quad_t                quad_next;
    logic [DEGW-1:0]      rem_full;
    quad_t                quad_reg;
    logic [TABIW-1:0]     rem_reg;
    logic signed [CW-1:0] s_tab;
    logic signed [CW-1:0] c_tab;
    logic signed [CW-1:0] sin_next;
    logic signed [CW-1:0] cos_next;
    logic signed [CW-1:0] sin_reg;
    logic signed [CW-1:0] cos_reg;

    always_comb
    begin
        ang = (deg >= DEGW'(360)) ? deg - DEGW'(360) : deg;
        if (ang < DEGW'(90))
        begin
            quad_next = QUAD_0;
            rem_full  = ang;
        end
        else if (ang < DEGW'(180))
        begin
            quad_next = QUAD_1;
            rem_full  = ang - DEGW'(90);
        end
        else if (ang < DEGW'(270))
        begin
            quad_next = QUAD_2;
            rem_full  = ang - DEGW'(180);
        end
        else
        begin
            quad_next = QUAD_3;
            rem_full  = ang - DEGW'(270);
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        rem_reg  <= rem_full[TABIW-1:0];
    end

    always_comb
    begin
        s_tab = $signed(CW'(SIN_TAB[rem_reg]));
        c_tab = $signed(CW'(COS_TAB[rem_reg]));
        case (quad_reg)
            QUAD_0:
            begin
                sin_next = s_tab;
                cos_next = c_tab;
            end
            QUAD_1:
            begin
                sin_next = c_tab;
                cos_next = -s_tab;
            end
            QUAD_2:
            begin
                sin_next = -s_tab;
                cos_next = -c_tab;
            end
            default:
            begin
                sin_next = -c_tab;
                cos_next = s_tab;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

[sv/vtp_row.sv]
// One rotation matrix row: two Q30 products, then two truncating accumulations.
module vtp_row import vtp_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [RW-1:0] v0,
    input  logic signed [CW-1:0] m0,
    input  logic signed [RW-1:0] v1,
    input  logic signed [CW-1:0] m1,
    output logic signed [RW-1:0] res
);

    logic signed [PRW-1:0] p0_reg;
    logic signed [PRW-1:0] p1_reg;
    logic signed [SW-1:0]  r0;
    logic signed [SW-1:0]  s;
    logic signed [SW-1:0]  res_full;
    logic signed [RW-1:0]  res_next;
    logic signed [RW-1:0]  res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= PRW'(v0) * PRW'(m0);
            p1_reg <= PRW'(v1) * PRW'(m1);
        end
    end

    // The first partial sum is truncated before the second product joins it.
    always_comb
    begin
        r0       = trunc_q30(SW'(p0_reg));
        s        = (r0 <<< 30) + SW'(p1_reg);
        res_full = trunc_q30(s);
        res_next = res_full[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

[sv/vtp_div.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
module vtp_div import vtp_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] d_reg   [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] lo_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   t;
        logic          ge;

        if (i == 0)
        begin : g_first
            // The high part is below the divisor unless the quotient overflows.
            assign rem_in = DW'(num >> QW);
            assign lo_in  = num[QW-1:0];
            assign q_in   = '0;
            assign d_in   = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        assign t  = {rem_in, lo_in[QW-1]};
        assign ge = t >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
                lo_reg[i]  <= {lo_in[QW-2:0], 1'b0};
                q_reg[i]   <= {q_in[QW-2:0], ge};
                d_reg[i]   <= d_in;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

[sv/vertex_transform_projection.sv]
// Top level of the vertex transform and perspective projection pipeline.
// Usage:
// - Input beats on s_tvalid/s_tready/s_tdata carry one vertex each (x, y, z).
// - Output beats on m_tvalid/m_tready carry the screen point in m_tdata and
//   the depth-zero and saturation flags in m_tuser.
// - Registers are written through cfg_we/cfg_addr/cfg_wdata while no vertex
//   is in flight.
// - One vertex is taken per cycle while s_tready is high. A beat passes through
//   centering, scaling, three rotations and projection setup, the
//   bit-per-stage divider, and the output register before it shows on
//   m_tvalid.
// - When the receiver stalls, the last pipeline result drops into a one-beat
//   skid register and the whole pipeline holds; s_tready falls only while
//   that skid register is full, so nothing is lost or repeated.
// - Reset clears the valid bits, the skid flag and the registers to their
//   defaults (no translation, unity scale, no rotation).
module vertex_transform_projection import vtp_pkg::*;
#(
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480,
    parameter int FOCAL    = 120
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [ADDRW-1:0] cfg_addr,
    input  logic [CFGW-1:0]  cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // vertex_x, vertex_y, vertex_z, pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // screen_x, screen_y
    output logic [1:0]       m_tuser    // depth_zero, saturated
);

    localparam int LAT = 14 + QW;
    localparam logic signed [SW16-1:0] SCR [3] = '{SW16'(SCREEN_W), SW16'(SCREEN_H), '0};
    localparam logic signed [NW-1:0]   FOC_N   = NW'(FOCAL);
    localparam logic signed [XW-1:0]   FOC_X   = XW'(FOCAL);

    // Configuration registers.
    logic signed [TW-1:0] trans_reg [3];
    logic [PCTW-1:0]      pct_reg   [3];
    logic [ROTW-1:0]      rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trans_reg[i] <= '0;
                pct_reg[i]   <= PCTW'(100);
            end
            rot_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_TRANS_X: trans_reg[0] <= $signed(cfg_wdata[TW-1:0]);
                REG_TRANS_Y: trans_reg[1] <= $signed(cfg_wdata[TW-1:0]);
                REG_TRANS_Z: trans_reg[2] <= $signed(cfg_wdata[TW-1:0]);
                REG_SCALE_X: pct_reg[0]   <= cfg_wdata[PCTW-1:0];
                REG_SCALE_Y: pct_reg[1]   <= cfg_wdata[PCTW-1:0];
                REG_SCALE_Z: pct_reg[2]   <= cfg_wdata[PCTW-1:0];
                REG_ROT:     rot_reg      <= cfg_wdata[ROTW-1:0];
                default:     ;
            endcase
        end
    end

    // Rotation sines and cosines follow the angle register.
    logic signed [CW-1:0] sin_a [3];
    logic signed [CW-1:0] cos_a [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_trig
        vtp_trig u_trig
        (
            .clk   (clk),
            .deg   (rot_reg[g*DEGW +: DEGW]),
            .sin_q (sin_a[g]),
            .cos_q (cos_a[g])
        );
    end

    // Handshake and valid tracking.
    logic           en;
    logic           s_acc;
    logic [LAT-1:0] vld_reg;
    logic           skid_full_reg;

    assign en       = !skid_full_reg;
    assign s_tready = en;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_acc};
    end

    logic signed [VW-1:0] vin [3];
    assign vin[0] = $signed(s_tdata[VW-1:0]);
    assign vin[1] = $signed(s_tdata[2*VW-1:VW]);
    assign vin[2] = $signed(s_tdata[3*VW-1:2*VW]);

    // Centering, scale product, reciprocal product, scaled value.
    logic signed [AW-1:0] ctr_reg  [3];
    logic                 pneg_reg [3];
    logic [MW-1:0]        pmag_reg [3];
    logic                 rneg_reg [3];
    logic [MW+RCPW-1:0]   rq_reg   [3];
    logic signed [RW-1:0] scl_reg  [3];

    logic signed [SW16-1:0] ctr_next [3];
    logic signed [PW-1:0]   prod     [3];
    logic [BW-2:0]          qmag     [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctr_next[i] = half_trunc((SW16'(vin[i]) <<< 1) - SCR[i]
                                     - (SW16'(trans_reg[i]) <<< 1))
                          + SW16'(trans_reg[i]);
            prod[i]     = PW'(ctr_reg[i]) * PW'($signed({1'b0, pct_reg[i]}));
            qmag[i]     = rq_reg[i][RSH +: BW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctr_reg[i]  <= ctr_next[i][AW-1:0];
                pneg_reg[i] <= prod[i][PW-1];
                pmag_reg[i] <= prod[i][PW-1] ? MW'(-prod[i]) : MW'(prod[i]);
                rneg_reg[i] <= pneg_reg[i];
                rq_reg[i]   <= (MW+RCPW)'(pmag_reg[i]) * (MW+RCPW)'(RCP100);
                scl_reg[i]  <= rneg_reg[i] ? -RW'($signed({1'b0, qmag[i]}))
                                           :  RW'($signed({1'b0, qmag[i]}));
            end
        end
    end

    // Rotation about Z, then Y, then X; each row registers its products, then its result.
    logic signed [CW-1:0] nsin [3];
    assign nsin[0] = -sin_a[0];
    assign nsin[1] = -sin_a[1];
    assign nsin[2] = -sin_a[2];

    logic signed [RW-1:0] zr0, zr1, yr0, yr2, xr1, xr2;
    logic signed [RW-1:0] b2_d1_reg, b2_d2_reg, a1_d1_reg, a1_d2_reg, b0_d1_reg, b0_d2_reg;

    vtp_row u_rz0 (.clk(clk), .en(en), .v0(scl_reg[0]), .m0(cos_a[2]),
                   .v1(scl_reg[1]), .m1(nsin[2]), .res(zr0));
    vtp_row u_rz1 (.clk(clk), .en(en), .v0(scl_reg[0]), .m0(sin_a[2]),
                   .v1(scl_reg[1]), .m1(cos_a[2]), .res(zr1));
    vtp_row u_ry0 (.clk(clk), .en(en), .v0(zr0), .m0(cos_a[1]),
                   .v1(b2_d2_reg), .m1(sin_a[1]), .res(yr0));
    vtp_row u_ry2 (.clk(clk), .en(en), .v0(zr0), .m0(nsin[1]),
                   .v1(b2_d2_reg), .m1(cos_a[1]), .res(yr2));
    vtp_row u_rx1 (.clk(clk), .en(en), .v0(a1_d2_reg), .m0(cos_a[0]),
                   .v1(yr2), .m1(nsin[0]), .res(xr1));
    vtp_row u_rx2 (.clk(clk), .en(en), .v0(a1_d2_reg), .m0(sin_a[0]),
                   .v1(yr2), .m1(cos_a[0]), .res(xr2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_d1_reg <= scl_reg[2];
            b2_d2_reg <= b2_d1_reg;
            a1_d1_reg <= zr1;
            a1_d2_reg <= a1_d1_reg;
            b0_d1_reg <= yr0;
            b0_d2_reg <= b0_d1_reg;
        end
    end

    // Move back from the screen center, then build numerator and divisor.
    logic signed [SW16-1:0] hc_x, hc_y;
    logic signed [XW-1:0]   posx_reg, posy_reg, dep_reg;
    logic signed [NW-1:0]   mx_reg, my_reg, wdx_reg, wdy_reg;
    logic signed [XW-1:0]   dd_reg;
    logic signed [NW-1:0]   numx_reg, numy_reg;
    logic signed [DW-1:0]   den_reg;
    logic [NW-1:0]          nmagx_reg, nmagy_reg;
    logic [DW-1:0]          dmag_reg;
    side_t                  side_next;
    side_t                  side_st_reg;
    side_t                  side_reg [QW];

    assign hc_x = half_trunc(SCR[0] + (SW16'(trans_reg[0]) <<< 1));
    assign hc_y = half_trunc(SCR[1] + (SW16'(trans_reg[1]) <<< 1));

    always_comb
    begin
        side_next.neg_x = side_st_reg.neg_x;
        side_next.neg_y = side_st_reg.neg_y;
        side_next.ovf_x = (nmagx_reg >> QW) >= NW'(dmag_reg);
        side_next.ovf_y = (nmagy_reg >> QW) >= NW'(dmag_reg);
        side_next.dz    = side_st_reg.dz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            posx_reg  <= XW'(b0_d2_reg) + XW'(hc_x);
            posy_reg  <= XW'(xr1) + XW'(hc_y);
            dep_reg   <= XW'(xr2) + XW'(trans_reg[2]) + FOC_X;
            mx_reg    <= ((NW'(posx_reg) <<< 1) - NW'(SCR[0])) * FOC_N;
            my_reg    <= ((NW'(posy_reg) <<< 1) - NW'(SCR[1])) * FOC_N;
            wdx_reg   <= NW'(SCR[0]) * NW'(dep_reg);
            wdy_reg   <= NW'(SCR[1]) * NW'(dep_reg);
            dd_reg    <= dep_reg;
            numx_reg  <= mx_reg + wdx_reg;
            numy_reg  <= my_reg + wdy_reg;
            den_reg   <= DW'(dd_reg) <<< 1;
            nmagx_reg <= numx_reg[NW-1] ? NW'(-numx_reg) : NW'(numx_reg);
            nmagy_reg <= numy_reg[NW-1] ? NW'(-numy_reg) : NW'(numy_reg);
            dmag_reg  <= den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
            side_st_reg <= '{neg_x: numx_reg[NW-1] ^ den_reg[DW-1],
                             neg_y: numy_reg[NW-1] ^ den_reg[DW-1],
                             ovf_x: 1'b0,
                             ovf_y: 1'b0,
                             dz:    den_reg == '0};
            side_reg[0] <= side_next;
            for (int i = 1; i < QW; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // The overflow compare needs the magnitudes, so the stage-14 flags are
    // combined with them on the way into the side chain.
    logic [QW-1:0] qx, qy;

    vtp_div u_div_x (.clk(clk), .en(en), .num(nmagx_reg), .den(dmag_reg), .quo(qx));
    vtp_div u_div_y (.clk(clk), .en(en), .num(nmagy_reg), .den(dmag_reg), .quo(qy));

    // Sign, saturation and the zero-depth case.
    res_t pipe_res;
    logic sat_x, sat_y;
    logic signed [OW-1:0] val_x, val_y;
    side_t side_out;

    assign side_out = side_reg[QW-1];

    always_comb
    begin
        if (side_out.ovf_x || (!side_out.neg_x && qx > QW'(32767))
            || (side_out.neg_x && qx > QW'(32768)))
        begin
            sat_x = 1'b1;
            val_x = side_out.neg_x ? $signed(16'h8000) : $signed(16'h7FFF);
        end
        else
        begin
            sat_x = 1'b0;
            val_x = side_out.neg_x ? OW'(-qx) : OW'(qx);
        end
        if (side_out.ovf_y || (!side_out.neg_y && qy > QW'(32767))
            || (side_out.neg_y && qy > QW'(32768)))
        begin
            sat_y = 1'b1;
            val_y = side_out.neg_y ? $signed(16'h8000) : $signed(16'h7FFF);
        end
        else
        begin
            sat_y = 1'b0;
            val_y = side_out.neg_y ? OW'(-qy) : OW'(qy);
        end
        if (side_out.dz)
        begin
            pipe_res = '0;
            pipe_res.depth_zero = 1'b1;
        end
        else
        begin
            pipe_res.saturated  = sat_x || sat_y;
            pipe_res.depth_zero = 1'b0;
            pipe_res.screen_x   = val_x;
            pipe_res.screen_y   = val_y;
        end
    end

    // Output register with a one-beat skid register behind it.
    logic out_valid_reg;
    logic out_load;
    logic pipe_v;
    res_t out_reg, skid_reg;

    assign out_load = !out_valid_reg || m_tready;
    assign pipe_v   = en && vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end
        else if (out_load)
            out_valid_reg <= pipe_v;
        else if (pipe_v)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_load)
                out_reg <= skid_reg;
        end
        else if (out_load)
            out_reg <= pipe_res;
        else if (pipe_v)
            skid_reg <= pipe_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.screen_y, out_reg.screen_x};
    assign m_tuser  = {out_reg.saturated, out_reg.depth_zero};

endmodule

[sv/vtp_check.sv]
// Port-level checks of the vertex transform, bound to the top level.
module vtp_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A beat offered and not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat withdrawn while stalled");

    // Input backpressure only follows an output stall.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // A zero divisor gives a zero point and no saturation.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0 && !m_tuser[1])
        else $error("depth-zero beat carries data");

    // A saturated beat has a coordinate at a 16-bit limit.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8000)
        else $error("saturated beat without a clamped coordinate");

    // Nothing is shown in the cycle reset is released.
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind vertex_transform_projection vtp_check u_vtp_check (.*);
